### rtl/c3f_pkg.sv
package c3f_pkg;

    localparam int KSIZE      = 3;
    localparam int KW         = 8;
    localparam int DIM_W      = 11;
    localparam int POS_W      = 10;
    localparam int FILT_W     = 20;
    localparam int OUT_W      = FILT_W + 2 * POS_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = KSIZE * KW;
    localparam int DIM_MIN    = 3;
    localparam int MAX_HEIGHT = 1024;

    localparam logic [DIM_W-1:0] RESET_DIM = 11'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_K_TOP  = 3'd2,
        REG_K_MID  = 3'd3,
        REG_K_BOT  = 3'd4
    } t_cfg_reg;

    // Kernel row r, column c at [r][c]; column 0 sits in the low byte of a row.
    typedef logic [KSIZE-1:0][KSIZE-1:0][KW-1:0] t_kernel;

    typedef struct packed {
        logic [POS_W-1:0] center_row;
        logic [POS_W-1:0] center_col;
        logic             last;
    } t_tag;

endpackage

### rtl/c3f_ram.sv
module c3f_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

### rtl/c3f_linebuf.sv
module c3f_linebuf
    import c3f_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [PIXEL_BITS-1:0]          i_pixel,
    input  logic [$clog2(MAX_WIDTH+1)-1:0] i_width,
    input  logic [DIM_W-1:0]               i_height,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [PIXEL_BITS-1:0]          o_win [KSIZE][KSIZE],
    output t_tag                           o_tag
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WD_W  = $clog2(MAX_WIDTH + 1);

    logic [COL_W-1:0]        r_col, n_col;
    logic [POS_W-1:0]        r_row, n_row;
    logic                    r_v1;
    logic [PIXEL_BITS-1:0]   r_px1;
    logic [COL_W-1:0]        r_slot1;
    logic                    r_emit1;
    t_tag                    r_tag1, n_tag;
    logic                    r_v2;
    t_tag                    r_tag2;
    logic [PIXEL_BITS-1:0]   r_win [KSIZE][KSIZE];

    logic                    row_end, img_end, emit;
    logic                    rdy1, rdy2, acc, adv1;
    logic [2*PIXEL_BITS-1:0] ram_q, ram_wdata;

    assign rdy2    = !r_v2 || i_ready;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign acc     = i_valid && rdy1;
    assign adv1    = r_v1 && rdy2;

    assign row_end = (WD_W'(r_col) + WD_W'(1)) >= i_width;
    assign img_end = row_end && (({1'b0, r_row} + DIM_W'(1)) >= i_height);
    assign emit    = (r_row >= POS_W'(2)) && (r_col >= COL_W'(2));

    always_comb begin
        n_tag.center_row = r_row - POS_W'(1);
        n_tag.center_col = POS_W'(r_col - COL_W'(1));
        n_tag.last       = img_end;
        if (img_end) begin
            n_row = '0;
            n_col = '0;
        end else if (row_end) begin
            n_row = r_row + POS_W'(1);
            n_col = '0;
        end else begin
            n_row = r_row;
            n_col = r_col + COL_W'(1);
        end
    end

    // Each entry holds the column two rows up (high half) and one row up (low half).
    // The pixel's read goes out at acceptance; the shifted pair is written back as it
    // advances. Back-to-back pixels never share a column, so no forwarding is needed.
    assign ram_wdata = {ram_q[PIXEL_BITS-1:0], r_px1};

    c3f_ram #(
        .WIDTH(2 * PIXEL_BITS),
        .DEPTH(MAX_WIDTH)
    ) u_lines (
        .i_clk    (i_clk),
        .i_wr_en  (adv1),
        .i_wr_addr(r_slot1),
        .i_wr_data(ram_wdata),
        .i_rd_en  (acc),
        .i_rd_addr(r_col),
        .o_rd_data(ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            for (int r = 0; r < KSIZE; r++) begin
                for (int c = 0; c < KSIZE; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else begin
            if (acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1 && r_emit1;
            end
            if (adv1) begin
                for (int r = 0; r < KSIZE; r++) begin
                    for (int c = 0; c < KSIZE - 1; c++) begin
                        r_win[r][c] <= r_win[r][c+1];
                    end
                end
                r_win[0][KSIZE-1] <= ram_q[2*PIXEL_BITS-1:PIXEL_BITS];
                r_win[1][KSIZE-1] <= ram_q[PIXEL_BITS-1:0];
                r_win[2][KSIZE-1] <= r_px1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_px1   <= i_pixel;
            r_slot1 <= r_col;
            r_emit1 <= emit;
            r_tag1  <= n_tag;
        end
        if (adv1) begin
            r_tag2 <= r_tag1;
        end
    end

    assign o_valid = r_v2;
    assign o_tag   = r_tag2;
    assign o_win   = r_win;

endmodule

### rtl/c3f_mac.sv
module c3f_mac
    import c3f_pkg::*;
#(
    parameter int PIXEL_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [PIXEL_BITS-1:0] i_win [KSIZE][KSIZE],
    input  t_tag                  i_tag,
    input  t_kernel               i_kernel,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [FILT_W-1:0]     o_filtered,
    output t_tag                  o_tag
);

    // Unsigned pixel times signed weight, then four bits of growth for nine terms.
    localparam int PROD_W = PIXEL_BITS + KW + 1;
    localparam int ACC_W  = (PROD_W + 4 > FILT_W) ? PROD_W + 4 : FILT_W;

    logic signed [PROD_W-1:0] r_prod [KSIZE][KSIZE];
    logic signed [PROD_W-1:0] n_prod [KSIZE][KSIZE];
    logic signed [ACC_W-1:0]  r_rsum [KSIZE];
    logic signed [ACC_W-1:0]  n_rsum [KSIZE];
    logic signed [ACC_W-1:0]  n_sum;
    logic                     r_v3, r_v4, r_vo;
    t_tag                     r_tag3, r_tag4, r_tago;
    logic [FILT_W-1:0]        r_filt;
    logic                     rdy3, rdy4, rdyo;

    assign rdyo    = !r_vo || i_ready;
    assign rdy4    = !r_v4 || rdyo;
    assign rdy3    = !r_v3 || rdy4;
    assign o_ready = rdy3;

    always_comb begin
        for (int r = 0; r < KSIZE; r++) begin
            for (int c = 0; c < KSIZE; c++) begin
                n_prod[r][c] = PROD_W'($signed({1'b0, i_win[r][c]}))
                             * PROD_W'($signed(i_kernel[r][c]));
            end
        end
    end

    always_comb begin
        for (int r = 0; r < KSIZE; r++) begin
            n_rsum[r] = ACC_W'(r_prod[r][0]) + ACC_W'(r_prod[r][1])
                      + ACC_W'(r_prod[r][2]);
        end
        n_sum = r_rsum[0] + r_rsum[1] + r_rsum[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (rdy3) begin
                r_v3 <= i_valid;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
            if (rdyo) begin
                r_vo <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_prod <= n_prod;
            r_tag3 <= i_tag;
        end
        if (rdy4) begin
            r_rsum <= n_rsum;
            r_tag4 <= r_tag3;
        end
        if (rdyo) begin
            r_filt <= n_sum[FILT_W-1:0];
            r_tago <= r_tag4;
        end
    end

    assign o_valid    = r_vo;
    assign o_filtered = r_filt;
    assign o_tag      = r_tago;

endmodule

### rtl/conv3x3_image_filter.sv
// 3x3 correlation filter over a raster pixel stream. Pixels enter one per clock
// unless back-pressure stalls intake, and each interior pixel yields one result
// once the pixel completing its window (the window's bottom-right pixel) is
// accepted; border pixels yield nothing. The two previous rows sit in one simple
// dual-port RAM, MAX_WIDTH entries of two pixels, read when a pixel is accepted
// and written back as it leaves the first stage, so the line stores need no
// clearing pass after reset. A result waiting at the output does not stop intake
// until the four pipeline stages behind it are full. Image size and kernel rows
// are set through the config port between images, with the block drained; width
// and height are clamped to at least 3 and at most MAX_WIDTH and 1024.
module conv3x3_image_filter
    import c3f_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]                i_cfg_index,
    input  logic [CFG_DATA_W-1:0]               i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // pixel
    input  logic [((PIXEL_BITS+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // filtered, center_row, center_col
    output logic [OUT_W-1:0]                    m_axis_tdata,
    output logic                                m_axis_tlast
);

    localparam int WD_W = $clog2(MAX_WIDTH + 1);

    logic [WD_W-1:0]       r_width;
    logic [DIM_W-1:0]      r_height;
    t_kernel               r_kernel;
    logic                  cfg_wr;
    logic                  lb_valid, mac_ready;
    logic [PIXEL_BITS-1:0] lb_win [KSIZE][KSIZE];
    t_tag                  lb_tag, out_tag;
    logic [FILT_W-1:0]     out_filt;

    function automatic logic [WD_W-1:0] clamp_width(input logic [DIM_W-1:0] v);
        if (v < DIM_W'(DIM_MIN)) begin
            return WD_W'(DIM_MIN);
        end else if (32'(v) > MAX_WIDTH) begin
            return WD_W'(MAX_WIDTH);
        end
        return WD_W'(v);
    endfunction

    function automatic logic [DIM_W-1:0] clamp_height(input logic [DIM_W-1:0] v);
        if (v < DIM_W'(DIM_MIN)) begin
            return DIM_W'(DIM_MIN);
        end else if (v > DIM_W'(MAX_HEIGHT)) begin
            return DIM_W'(MAX_HEIGHT);
        end
        return v;
    endfunction

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= clamp_width(RESET_DIM);
            r_height <= clamp_height(RESET_DIM);
            r_kernel <= '0;
        end else if (cfg_wr) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_WIDTH:  r_width     <= clamp_width(i_cfg_data[DIM_W-1:0]);
                REG_HEIGHT: r_height    <= clamp_height(i_cfg_data[DIM_W-1:0]);
                REG_K_TOP:  r_kernel[0] <= i_cfg_data;
                REG_K_MID:  r_kernel[1] <= i_cfg_data;
                REG_K_BOT:  r_kernel[2] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    c3f_linebuf #(
        .MAX_WIDTH (MAX_WIDTH),
        .PIXEL_BITS(PIXEL_BITS)
    ) u_linebuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_pixel (s_axis_tdata[PIXEL_BITS-1:0]),
        .i_width (r_width),
        .i_height(r_height),
        .o_valid (lb_valid),
        .i_ready (mac_ready),
        .o_win   (lb_win),
        .o_tag   (lb_tag)
    );

    c3f_mac #(
        .PIXEL_BITS(PIXEL_BITS)
    ) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (lb_valid),
        .o_ready   (mac_ready),
        .i_win     (lb_win),
        .i_tag     (lb_tag),
        .i_kernel  (r_kernel),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_filtered(out_filt),
        .o_tag     (out_tag)
    );

    assign m_axis_tdata = {out_tag.center_col, out_tag.center_row, out_filt};
    assign m_axis_tlast = out_tag.last;

endmodule

### rtl/c3f_checker.sv
module c3f_checker
    import c3f_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic             m_axis_tlast
);

    logic [POS_W-1:0] row, col;

    assign row = m_axis_tdata[FILT_W+POS_W-1:FILT_W];
    assign col = m_axis_tdata[OUT_W-1:FILT_W+POS_W];

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // Reset leaves no result in the output stage.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result present after reset");

    // A window center is never on the top row or left column.
    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> row != '0 && col != '0)
        else $error("result centered on a border pixel");

    // Within one row of one image, results come out column by column.
    a_cols: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) ##1
            (m_axis_tvalid && row == $past(row)) |->
            col == POS_W'($past(col) + POS_W'(1)))
        else $error("result columns out of order");

endmodule

bind conv3x3_image_filter c3f_checker u_c3f_checker (.*);
